>>> src/qadd_pkg.sv
`default_nettype none

package qadd_pkg;

   // Fixed left shift applied to each operand after its offset is added.
   localparam int unsigned PRE_SHIFT = 20;

   // Number of register stages from the input transfer to the result register.
   localparam int unsigned NUM_STAGES = 9;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 31;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FIRST_OFFSET      = 3'd0,
      CSR_SECOND_OFFSET     = 3'd1,
      CSR_RESULT_OFFSET     = 3'd2,
      CSR_FIRST_MULTIPLIER  = 3'd3,
      CSR_SECOND_MULTIPLIER = 3'd4,
      CSR_RESULT_MULTIPLIER = 3'd5,
      CSR_SHIFT_AMOUNTS     = 3'd6,
      CSR_CLAMP_BOUNDS      = 3'd7
   } csr_index_type;

   localparam logic [30:0] MULTIPLIER_RESET = 31'h4000_0000;
   localparam logic [15:0] CLAMP_RESET      = 16'h7F80;

   // Rounding bias of the doubling high multiply: 2^30.
   localparam logic signed [63:0] HIGH_MUL_NUDGE = 64'sh0000_0000_4000_0000;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] product_type;

   // Left part of a signed 6-bit shift: max(shift, 0).
   function automatic logic [4:0] left_amount(input logic [5:0] shift);
      return shift[5] ? 5'd0 : shift[4:0];
   endfunction

   // Right part of a signed 6-bit shift: max(-shift, 0), 0 to 32.
   function automatic logic [5:0] right_amount(input logic [5:0] shift);
      return shift[5] ? 6'(~shift + 6'd1) : 6'd0;
   endfunction

   // Arithmetic right shift that rounds half away from zero.
   function automatic word_type round_shift(input word_type value,
                                            input logic [5:0] amount);
      logic signed [32:0] ext;
      logic signed [32:0] quot;
      logic [32:0]        mask;
      logic [32:0]        rem;
      logic [32:0]        thr;
      ext  = {value[31], value};
      quot = ext >>> amount;
      mask = (33'd1 << amount) - 33'd1;
      rem  = 33'(ext) & mask;
      thr  = (mask >> 1) + {32'd0, value[31]};
      return word_type'(quot[31:0] + {31'd0, (rem > thr)});
   endfunction

endpackage

`default_nettype wire

>>> src/quantized_int8_elementwise_add.sv
// Quantized int8 elementwise add.
//
// The request channel carries one pair of int8 elements and a last flag per
// transfer; the response channel returns their quantized int8 sum and the
// copied last flag, one response per request, in order. Both channels use
// valid and stall: a transfer happens at a clock edge where valid is high and
// stall is low.
//
// The datapath is a nine-stage pipeline, stages 0 to 8, and rsp_valid comes
// from the valid bit of stage 8. One request is taken every cycle while
// req_stall is low. The 32 by 31 bit multiplies sit in stages of their own.
//
// A stall on the response side holds the result register. Empty stages ahead
// of a stalled one keep filling, so req_stall rises only once every stage
// holds an item. Nothing is lost or repeated.
//
// Synchronous reset empties the pipeline and loads the default configuration:
// zero offsets and shifts, multipliers of one half and the full int8 clamp
// range. Configuration is written through the csr port; the user must do so
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module quantized_int8_elementwise_add (
   input  wire                                   clock,
   input  wire                                   reset,
   // Request channel.
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [7:0]                     req_elem_a,
   input  wire  signed [7:0]                     req_elem_b,
   input  wire                                   req_in_last,
   // Response channel.
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [7:0]                     rsp_sum_out,
   output logic                                  rsp_out_last,
   // Configuration write port.
   input  wire                                   csr_wr_en,
   input  wire  [qadd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [qadd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import qadd_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic signed [8:0] first_offset_ff;
   logic signed [8:0] second_offset_ff;
   logic signed [7:0] result_offset_ff;
   logic [30:0]       first_multiplier_ff;
   logic [30:0]       second_multiplier_ff;
   logic [30:0]       result_multiplier_ff;
   logic [17:0]       shift_amounts_ff;
   logic [15:0]       clamp_bounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_offset_ff      <= '0;
         second_offset_ff     <= '0;
         result_offset_ff     <= '0;
         first_multiplier_ff  <= MULTIPLIER_RESET;
         second_multiplier_ff <= MULTIPLIER_RESET;
         result_multiplier_ff <= MULTIPLIER_RESET;
         shift_amounts_ff     <= '0;
         clamp_bounds_ff      <= CLAMP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_OFFSET:      first_offset_ff      <= csr_wdata[8:0];
            CSR_SECOND_OFFSET:     second_offset_ff     <= csr_wdata[8:0];
            CSR_RESULT_OFFSET:     result_offset_ff     <= csr_wdata[7:0];
            CSR_FIRST_MULTIPLIER:  first_multiplier_ff  <= csr_wdata[30:0];
            CSR_SECOND_MULTIPLIER: second_multiplier_ff <= csr_wdata[30:0];
            CSR_RESULT_MULTIPLIER: result_multiplier_ff <= csr_wdata[30:0];
            CSR_SHIFT_AMOUNTS:     shift_amounts_ff     <= csr_wdata[17:0];
            CSR_CLAMP_BOUNDS:      clamp_bounds_ff      <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Decoded configuration. Lane 0 is the first operand, lane 1 the second.
   logic [4:0]        lane_lsh [2];
   logic [5:0]        lane_rsh [2];
   logic signed [8:0] lane_offset [2];
   logic [30:0]       lane_mult [2];
   logic [4:0]        result_lsh;
   logic [5:0]        result_rsh;
   logic signed [7:0] clamp_lo;
   logic signed [7:0] clamp_hi;

   always_comb begin
      lane_lsh[0]    = left_amount(shift_amounts_ff[5:0]);
      lane_lsh[1]    = left_amount(shift_amounts_ff[11:6]);
      lane_rsh[0]    = right_amount(shift_amounts_ff[5:0]);
      lane_rsh[1]    = right_amount(shift_amounts_ff[11:6]);
      lane_offset[0] = first_offset_ff;
      lane_offset[1] = second_offset_ff;
      lane_mult[0]   = first_multiplier_ff;
      lane_mult[1]   = second_multiplier_ff;
      result_lsh     = left_amount(shift_amounts_ff[17:12]);
      result_rsh     = right_amount(shift_amounts_ff[17:12]);
      clamp_lo       = clamp_bounds_ff[7:0];
      clamp_hi       = clamp_bounds_ff[15:8];
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it loads; the result register loads unless it holds a
   // response that is stalled.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] last_ff;
   logic [NUM_STAGES:0]   move;

   always_comb begin
      move[NUM_STAGES] = !rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         move[i] = !valid_ff[i] || move[i+1];
      end
   end

   assign req_stall = !move[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (move[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (move[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         last_ff[0] <= req_in_last;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (move[i]) begin
            last_ff[i] <= last_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Operand lanes.
   // ------------------------------------------------------------------
   // Stage 0: add the offset and shift left by the fixed pre-shift plus the
   // operand's left shift, wrapping at 32 bits.
   word_type          s0_y_ff [2];
   word_type          s0_y_in [2];
   logic signed [9:0] lane_sum [2];
   logic signed [7:0] lane_elem [2];
   logic [6:0]        lane_total_shift [2];

   always_comb begin
      lane_elem[0] = req_elem_a;
      lane_elem[1] = req_elem_b;
      for (int l = 0; l < 2; l++) begin
         lane_sum[l]         = 10'(lane_elem[l]) + 10'(lane_offset[l]);
         lane_total_shift[l] = 7'(PRE_SHIFT) + 7'(lane_lsh[l]);
         s0_y_in[l]          = word_type'(32'(lane_sum[l]) << lane_total_shift[l]);
      end
   end

   // Stage 1: multiply by the Q31 multiplier.
   product_type s1_prod_ff [2];
   product_type s1_prod_in [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         s1_prod_in[l] = 64'(s0_y_ff[l]) * 64'($signed({1'b0, lane_mult[l]}));
      end
   end

   // Stage 2: rounding high half of the doubled product. The nudge of the
   // round-half-away form folds into one bias followed by a floor shift.
   word_type    s2_hi_ff [2];
   word_type    s2_hi_in [2];
   product_type lane_biased [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         lane_biased[l] = s1_prod_ff[l] + HIGH_MUL_NUDGE;
         s2_hi_in[l]    = word_type'(lane_biased[l][62:31]);
      end
   end

   // Stage 3: rounding right shift by the operand's right shift.
   word_type s3_scaled_ff [2];
   word_type s3_scaled_in [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         s3_scaled_in[l] = round_shift(s2_hi_ff[l], lane_rsh[l]);
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (move[0]) begin
            s0_y_ff[l] <= s0_y_in[l];
         end
         if (move[1]) begin
            s1_prod_ff[l] <= s1_prod_in[l];
         end
         if (move[2]) begin
            s2_hi_ff[l] <= s2_hi_in[l];
         end
         if (move[3]) begin
            s3_scaled_ff[l] <= s3_scaled_in[l];
         end
      end
   end

   // ------------------------------------------------------------------
   // Result path.
   // ------------------------------------------------------------------
   // Stage 4: add the scaled operands and apply the result left shift, both
   // wrapping at 32 bits.
   word_type    s4_y_ff;
   word_type    s4_y_in;
   logic [31:0] scaled_sum;

   // Stage 5: multiply by the result multiplier.
   product_type s5_prod_ff;
   product_type s5_prod_in;

   // Stage 6: rounding high half.
   word_type    s6_hi_ff;
   word_type    s6_hi_in;
   product_type result_biased;

   // Stage 7: rounding right shift.
   word_type    s7_res_ff;
   word_type    s7_res_in;

   // Stage 8: add the zero point and clamp to the activation range.
   logic signed [7:0]  s8_sum_ff;
   logic signed [7:0]  s8_sum_in;
   logic signed [32:0] with_offset;

   always_comb begin
      scaled_sum    = 32'(s3_scaled_ff[0]) + 32'(s3_scaled_ff[1]);
      s4_y_in       = word_type'(scaled_sum << result_lsh);
      s5_prod_in    = 64'(s4_y_ff) * 64'($signed({1'b0, result_multiplier_ff}));
      result_biased = s5_prod_ff + HIGH_MUL_NUDGE;
      s6_hi_in      = word_type'(result_biased[62:31]);
      s7_res_in     = round_shift(s6_hi_ff, result_rsh);
      with_offset   = 33'(s7_res_ff) + 33'(result_offset_ff);
      // The maximum bound is checked first, then the minimum, and inverted bounds
      // are forced to the maximum. Both bounds are int8, so the result always fits.
      if (with_offset > 33'(clamp_hi)) begin
         s8_sum_in = clamp_hi;
      end else if (with_offset < 33'(clamp_lo)) begin
         s8_sum_in = clamp_lo;
      end else begin
         s8_sum_in = with_offset[7:0];
      end
      if (clamp_lo > clamp_hi) begin
         s8_sum_in = clamp_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (move[4]) begin
         s4_y_ff <= s4_y_in;
      end
      if (move[5]) begin
         s5_prod_ff <= s5_prod_in;
      end
      if (move[6]) begin
         s6_hi_ff <= s6_hi_in;
      end
      if (move[7]) begin
         s7_res_ff <= s7_res_in;
      end
      if (move[8]) begin
         s8_sum_ff <= s8_sum_in;
      end
   end

   assign rsp_valid    = valid_ff[NUM_STAGES-1];
   assign rsp_sum_out  = s8_sum_ff;
   assign rsp_out_last = last_ff[NUM_STAGES-1];

endmodule

`default_nettype wire

>>> tb/quantized_int8_elementwise_add_tb.sv
`default_nettype none

// Self-checking bench for the quantized int8 elementwise add.
//
// Every accepted request transfer is run through a bit-exact software copy of
// the datapath, using the configuration the bench last wrote, and the expected
// sum and last flag are queued. Each accepted response transfer is compared
// with the oldest queued expectation. The test tasks below are called in turn
// from one initial block. They share send_pair, which offers one element pair,
// and they share the response checker process.
module quantized_int8_elementwise_add_tb;
   import qadd_pkg::*;

   // One expected response: the clamped sum and the copied last flag.
   typedef struct {
      logic signed [7:0] sum;
      logic              last;
   } sum_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel, driven by the bench.
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic signed [7:0]          req_elem_a  = '0;
   logic signed [7:0]          req_elem_b  = '0;
   logic                       req_in_last = 1'b0;

   // Response channel; the bench drives the stall.
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [7:0]          rsp_sum_out;
   logic                       rsp_out_last;

   // Configuration write port.
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // The bench's own copy of the configuration, loaded with the reset values.
   logic signed [8:0] cfg_first_offset  = '0;
   logic signed [8:0] cfg_second_offset = '0;
   logic signed [7:0] cfg_result_offset = '0;
   logic [30:0]       cfg_first_mult    = MULTIPLIER_RESET;
   logic [30:0]       cfg_second_mult   = MULTIPLIER_RESET;
   logic [30:0]       cfg_result_mult   = MULTIPLIER_RESET;
   logic [17:0]       cfg_shifts        = '0;
   logic [15:0]       cfg_clamp         = CLAMP_RESET;

   sum_entry_type expected_sums[$];

   // Idle rates in percent, and a request for a long receiver hold-off.
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;

   int unsigned mismatch_count = 0;
   int unsigned sent_count     = 0;
   int unsigned result_count   = 0;
   int unsigned write_count    = 0;
   int unsigned stall_cycles   = 0;

   quantized_int8_elementwise_add i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_elem_a   (req_elem_a),
      .req_elem_b   (req_elem_b),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_sum_out  (rsp_sum_out),
      .rsp_out_last (rsp_out_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction.
   // ------------------------------------------------------------------------

   // Q31 rescale: a wrapping left shift by the positive part of the shift, a
   // rounding doubling high multiply, and a right shift by the negative part
   // that rounds half away from zero. The value x is within int32 range.
   function automatic longint rescale_q31(input longint x, input logic [30:0] mult,
                                          input logic signed [5:0] shift);
      int          sh;
      int unsigned lsh;
      int unsigned rsh;
      logic [31:0] shifted;
      longint      y;
      longint      prod;
      longint      nudge;
      longint      high;
      longint      quot;
      logic [63:0] biased;
      logic [63:0] mask;
      sh      = shift;
      lsh     = (sh > 0) ? sh : 0;
      rsh     = (sh < 0) ? -sh : 0;
      shifted = 32'(x);
      shifted = shifted << lsh;
      y       = longint'(signed'(shifted));
      prod    = y * longint'({1'b0, mult});
      nudge   = (prod >= 0) ? 64'sd1073741824 : 64'sd1 - 64'sd1073741824;
      high    = (prod + nudge) / 64'sd2147483648;
      // Bias the value positive so that the shift below is a plain one.
      biased  = high + 64'sd4294967296;
      mask    = (64'd1 << rsh) - 64'd1;
      quot    = longint'(biased >> rsh) - longint'(64'd4294967296 >> rsh);
      if ((biased & mask) > ((mask >> 1) + ((high < 0) ? 64'd1 : 64'd0)))
         quot = quot + 1;
      return quot;
   endfunction

   // Expected int8 sum of one element pair under the current configuration.
   function automatic logic signed [7:0] predict_sum(input logic signed [7:0] a,
                                                     input logic signed [7:0] b);
      longint      xa;
      longint      xb;
      longint      total;
      longint      lo;
      longint      hi;
      logic [31:0] w;
      xa = longint'(a) + longint'(cfg_first_offset);
      xb = longint'(b) + longint'(cfg_second_offset);
      w  = 32'(xa);
      w  = w << PRE_SHIFT;
      xa = longint'(signed'(w));
      w  = 32'(xb);
      w  = w << PRE_SHIFT;
      xb = longint'(signed'(w));
      xa = rescale_q31(xa, cfg_first_mult, cfg_shifts[5:0]);
      xb = rescale_q31(xb, cfg_second_mult, cfg_shifts[11:6]);
      // The sum of the two scaled operands wraps at 32 bits.
      w     = 32'(xa + xb);
      total = longint'(signed'(w));
      total = rescale_q31(total, cfg_result_mult, cfg_shifts[17:12])
              + longint'(cfg_result_offset);
      lo = longint'(signed'(cfg_clamp[7:0]));
      hi = longint'(signed'(cfg_clamp[15:8]));
      // The maximum is applied last, so inverted bounds give the maximum.
      if (total < lo) total = lo;
      if (total > hi) total = hi;
      if (total < -128) total = -128;
      if (total > 127) total = 127;
      return 8'(total);
   endfunction

   // ------------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------------

   function automatic void report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("MISMATCH at %0t: %s", $time, what);
   endfunction

   // A response transfer happens at an edge where rsp_valid is high and the
   // bench's own stall is low; both are read before the edge updates them.
   always @(posedge clock) begin : response_checker
      sum_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected: sum %0d last %0b",
                                      rsp_sum_out, rsp_out_last));
         end else begin
            want = expected_sums.pop_front();
            if (rsp_sum_out !== want.sum || rsp_out_last !== want.last)
               report_mismatch($sformatf("sum expected %0d got %0d, last expected %0b got %0b",
                                         want.sum, rsp_sum_out, want.last, rsp_out_last));
         end
      end
      if (!reset && req_valid && req_stall)
         stall_cycles++;
   end

   // Receiver pacing. A hold-off request keeps the stall high for a counted
   // stretch; otherwise the stall is random at the current idle rate.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Shared stimulus tasks. Each one is entered and left just after a rising
   // edge, so every drive below is a single nonblocking assignment per edge.
   // ------------------------------------------------------------------------

   // Offer one element pair, with random idle cycles first, and queue its
   // expected response once the request transfer has happened.
   task automatic send_pair(input logic signed [7:0] a, input logic signed [7:0] b,
                            input logic last);
      sum_entry_type entry;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_elem_a  <= a;
      req_elem_b  <= b;
      req_in_last <= last;
      do
         @(posedge clock);
      while (req_stall);
      entry.sum  = predict_sum(a, b);
      entry.last = last;
      expected_sums.push_back(entry);
      sent_count++;
   endtask

   // Stop offering and wait until every queued response has been checked.
   // Each pair gives exactly one response, so the pipeline is empty then.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_sums.size() != 0);
   endtask

   // Write one register and mirror it, masked to the register's width. The
   // enable drops for one cycle after each write.
   task automatic write_csr(input csr_index_type idx, input logic [30:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      write_count++;
      case (idx)
         CSR_FIRST_OFFSET:      cfg_first_offset  = data[8:0];
         CSR_SECOND_OFFSET:     cfg_second_offset = data[8:0];
         CSR_RESULT_OFFSET:     cfg_result_offset = data[7:0];
         CSR_FIRST_MULTIPLIER:  cfg_first_mult    = data[30:0];
         CSR_SECOND_MULTIPLIER: cfg_second_mult   = data[30:0];
         CSR_RESULT_MULTIPLIER: cfg_result_mult   = data[30:0];
         CSR_SHIFT_AMOUNTS:     cfg_shifts        = data[17:0];
         CSR_CLAMP_BOUNDS:      cfg_clamp         = data[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all_csrs(input logic [30:0] off1, input logic [30:0] off2,
                                 input logic [30:0] off3, input logic [30:0] mul1,
                                 input logic [30:0] mul2, input logic [30:0] mul3,
                                 input logic [30:0] shifts, input logic [30:0] clamp);
      write_csr(CSR_FIRST_OFFSET, off1);
      write_csr(CSR_SECOND_OFFSET, off2);
      write_csr(CSR_RESULT_OFFSET, off3);
      write_csr(CSR_FIRST_MULTIPLIER, mul1);
      write_csr(CSR_SECOND_MULTIPLIER, mul2);
      write_csr(CSR_RESULT_MULTIPLIER, mul3);
      write_csr(CSR_SHIFT_AMOUNTS, shifts);
      write_csr(CSR_CLAMP_BOUNDS, clamp);
   endtask

   // A typical setting keeps the output in range most of the time: input
   // shifts slightly negative, an output shift that undoes the pre-shift and
   // a clamp range that is usually full. Otherwise every bit is random.
   task automatic apply_random_setting(input bit typical);
      logic [5:0] sh1;
      logic [5:0] sh2;
      logic [5:0] sh3;
      logic [7:0] lo;
      logic [7:0] hi;
      if (typical) begin
         sh1 = 6'(-$urandom_range(0, 8));
         sh2 = 6'(-$urandom_range(0, 8));
         sh3 = 6'(-$urandom_range(14, 24));
         lo  = 8'($urandom_range(0, 128) - 128);
         hi  = 8'($urandom_range(0, 127));
         if ($urandom_range(99) < 60) begin
            lo = 8'h80;
            hi = 8'h7F;
         end
         write_all_csrs(31'($urandom_range(0, 256) - 128), 31'($urandom_range(0, 256) - 128),
                        31'($urandom_range(0, 255)),
                        31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)),
                        31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)),
                        31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)),
                        31'({sh3, sh2, sh1}), 31'({hi, lo}));
      end else begin
         write_all_csrs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                        31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Test tasks.
   // ------------------------------------------------------------------------

   // The reset configuration, with the element extremes.
   task automatic test_reset_defaults();
      send_pair(8'sd0, 8'sd0, 1'b0);
      send_pair(8'sd127, 8'sd127, 1'b1);
      send_pair(-8'sd128, -8'sd128, 1'b0);
      send_pair(8'sd127, -8'sd128, 1'b1);
      send_pair(-8'sd1, 8'sd1, 1'b0);
      wait_until_drained();
   endtask

   // Offsets of 128 and -128 and a left shift of 31: the pre-shifted operands and the
   // shift by two to the 31 keep only their low 32 bits.
   task automatic test_left_shift_overflow();
      write_all_csrs(31'h080, 31'h180, 31'h07F, 31'h7FFF_FFFF, 31'h4000_0000,
                     31'h4000_0000, 31'({6'sd31, 6'sd31, 6'sd31}), 31'(CLAMP_RESET));
      send_pair(8'sd127, 8'sd127, 1'b1);
      send_pair(-8'sd128, -8'sd128, 1'b0);
      send_pair(8'sd5, -8'sd7, 1'b1);
      wait_until_drained();
   endtask

   // Both scaled operands near the top of int32, so their sum wraps.
   task automatic test_sum_overflow();
      write_all_csrs(31'h080, 31'h080, 31'h080, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                     31'h7FFF_FFFF, 31'({-6'sd20, 6'sd3, 6'sd3}), 31'(CLAMP_RESET));
      send_pair(8'sd127, 8'sd127, 1'b0);
      send_pair(-8'sd128, -8'sd128, 1'b1);
      send_pair(8'sd127, -8'sd128, 1'b0);
      wait_until_drained();
   endtask

   // The largest right shift, 32, on every rescale.
   task automatic test_full_right_shift();
      write_csr(CSR_SHIFT_AMOUNTS, 31'({-6'sd32, -6'sd32, -6'sd32}));
      send_pair(8'sd127, 8'sd127, 1'b1);
      send_pair(-8'sd128, -8'sd128, 1'b0);
      wait_until_drained();
   endtask

   // Minimum above maximum: every result is the maximum.
   task automatic test_inverted_bounds();
      write_all_csrs(31'h0, 31'h0, 31'h0, 31'h4000_0000, 31'h4000_0000, 31'h4000_0000,
                     31'({-6'sd20, 6'sd0, 6'sd0}), 31'({8'sd20, 8'sd100}));
      send_pair(8'sd127, 8'sd127, 1'b0);
      send_pair(-8'sd128, -8'sd128, 1'b1);
      send_pair(8'sd3, 8'sd4, 1'b0);
      wait_until_drained();
   endtask

   // Every register all ones, then all zeros.
   task automatic test_register_extremes();
      write_all_csrs('1, '1, '1, '1, '1, '1, '1, '1);
      send_pair(8'sd127, -8'sd128, 1'b1);
      send_pair(-8'sd128, 8'sd127, 1'b0);
      wait_until_drained();
      write_all_csrs('0, '0, '0, '0, '0, '0, '0, '0);
      send_pair(8'sd127, 8'sd127, 1'b1);
      send_pair(-8'sd128, -8'sd128, 1'b0);
      wait_until_drained();
   endtask

   // Random settings, each followed by a burst of random element pairs.
   task automatic test_random_settings(input int unsigned settings,
                                       input int unsigned pairs);
      repeat (settings) begin
         apply_random_setting($urandom_range(99) < 70);
         repeat (pairs)
            send_pair(8'($urandom), 8'($urandom), 1'($urandom));
         wait_until_drained();
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the pipeline fills and the request side stalls.
   task automatic test_backpressure();
      apply_random_setting(1'b1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 80;
      repeat (40)
         send_pair(8'($urandom), 8'($urandom), 1'($urandom));
      wait_until_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the sender and receiver idling at random.
      req_idle_pct = 28;
      rsp_idle_pct = 57;
      test_reset_defaults();
      test_left_shift_overflow();
      test_sum_overflow();
      test_full_right_shift();
      test_inverted_bounds();
      test_register_extremes();

      // Random part: three idling regimes in turn.
      test_random_settings(5, 60);
      req_idle_pct = 57;
      rsp_idle_pct = 28;
      test_random_settings(5, 60);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_settings(5, 60);

      test_backpressure();

      // Give any stray response time to show up before the verdict.
      repeat (4 * NUM_STAGES) @(posedge clock);

      $display("Checked %0d of %0d request transfers across %0d register writes.",
               result_count, sent_count, write_count);
      $display("Request side stalled in %0d cycles; %0d mismatches.",
               stall_cycles, mismatch_count);
      if (mismatch_count == 0 && expected_sums.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
src/qadd_pkg.sv
src/quantized_int8_elementwise_add.sv
tb/quantized_int8_elementwise_add_tb.sv
